// ===== rtl/u8k_pkg.sv =====
// ============================================================================
// u8k_pkg
// Shared types, character codes and helper functions for the URL / UTF-8 to
// KOI8-R decoder.
// ============================================================================
package u8k_pkg;

   // escape tracking; the fourth code is never entered and acts as idle
   typedef enum logic [1:0] {
      PH_IDLE      = 2'd0,
      PH_AFTER_PCT = 2'd1,
      PH_ONE_DIGIT = 2'd2
   } phase_type;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] KOI_YO_CAP = 8'hB3;
   localparam logic [7:0] KOI_YO_SML = 8'hA3;
   localparam logic [10:0] CP_CYR_LO = 11'h410;
   localparam logic [10:0] CP_CYR_HI = 11'h44F;
   localparam logic [10:0] CP_YO_CAP = 11'h401;
   localparam logic [10:0] CP_YO_SML = 11'h451;

   // low five bits of the KOI8-R code, per alphabet position
   localparam logic [4:0] CYR_TAB [32] = '{
      5'h01, 5'h02, 5'h17, 5'h07, 5'h04, 5'h05, 5'h16, 5'h1A,
      5'h09, 5'h0A, 5'h0B, 5'h0C, 5'h0D, 5'h0E, 5'h0F, 5'h10,
      5'h12, 5'h13, 5'h14, 5'h15, 5'h06, 5'h08, 5'h03, 5'h1E,
      5'h1B, 5'h1D, 5'h1F, 5'h19, 5'h18, 5'h1C, 5'h00, 5'h11
   };

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] data;
      logic [7:0] prev;
   } dec_type;

   // up to three result beats produced by one input byte
   typedef struct packed {
      logic [1:0]       cnt;
      logic [2:0][7:0]  data;
      logic [2:0]       eos;
   } group_type;

   function automatic hex_type hex_value(input logic [7:0] c);
      hex_type h;
      h = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.ok  = 1'b1;
         h.val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.ok  = 1'b1;
         h.val = 4'(c[3:0] + 4'd9);
      end
      return h;
   endfunction

   // one byte through the two-byte UTF-8 decoder
   function automatic dec_type decode_byte(input logic [7:0] b, input logic [7:0] prev);
      dec_type     d;
      logic [10:0] cp;
      logic [10:0] off;
      d   = '0;
      cp  = {prev[4:0], b[5:0]};
      off = cp - CP_CYR_LO;
      if (!b[7]) begin
         d.emit = 1'b1;
         d.data = b;
         d.prev = b;
      end else if (prev[7:5] == 3'b110 && b[7:6] == 2'b10) begin
         d.prev = '0;
         if (cp >= CP_CYR_LO && cp <= CP_CYR_HI) begin
            d.emit = 1'b1;
            // capitals (below U+0430) land at 0xE0, small letters at 0xC0
            d.data = {2'b11, ~off[5], CYR_TAB[off[4:0]]};
         end else if (cp == CP_YO_CAP) begin
            d.emit = 1'b1;
            d.data = KOI_YO_CAP;
         end else if (cp == CP_YO_SML) begin
            d.emit = 1'b1;
            d.data = KOI_YO_SML;
         end
      end else begin
         d.prev = b;
      end
      return d;
   endfunction

endpackage

// ===== rtl/u8k_step.sv =====
// ============================================================================
// u8k_step
// Single-pass decode of one raw byte: escape handling, UTF-8 pairing and
// KOI8-R mapping, giving up to three result beats and the next state.
// ============================================================================
module u8k_step (
   input  logic [7:0]          in_byte,
   input  u8k_pkg::phase_type  phase,
   input  logic [7:0]          held,
   input  logic [7:0]          prev,
   output u8k_pkg::phase_type  phase_next,
   output logic [7:0]          held_next,
   output logic [7:0]          prev_next,
   output u8k_pkg::group_type  group
);
   import u8k_pkg::*;

   hex_type h_in;
   hex_type h_held;
   logic    is_term;

   assign h_in    = hex_value(in_byte);
   assign h_held  = hex_value(held);
   assign is_term = (in_byte == CH_NUL) || (in_byte == CH_SPACE);

   // next escape phase
   always_comb begin
      phase_next = PH_IDLE;
      case (phase)
         PH_AFTER_PCT: begin
            if (h_in.ok) begin
               phase_next = PH_ONE_DIGIT;
            end else if (in_byte == CH_PERCENT) begin
               phase_next = PH_AFTER_PCT;
            end
         end
         PH_ONE_DIGIT: begin
            if (!h_in.ok && in_byte == CH_PERCENT) begin
               phase_next = PH_AFTER_PCT;
            end
         end
         default: begin
            if (in_byte == CH_PERCENT) begin
               phase_next = PH_AFTER_PCT;
            end
         end
      endcase
   end

   // result beats, held digit and lead byte
   always_comb begin
      logic       do_a;
      logic [7:0] byte_a;
      logic       do_b;
      logic [7:0] byte_b;
      logic       do_raw;
      logic [1:0] n;
      dec_type    d;
      logic [7:0] p;

      do_a   = 1'b0;
      byte_a = CH_PERCENT;
      do_b   = 1'b0;
      byte_b = held;
      do_raw = 1'b0;
      d      = '0;
      held_next = held;
      case (phase)
         PH_AFTER_PCT: begin
            if (h_in.ok) begin
               held_next = in_byte;
            end else begin
               do_a   = 1'b1;
               do_raw = 1'b1;
            end
         end
         PH_ONE_DIGIT: begin
            held_next = '0;
            do_a      = 1'b1;
            if (h_in.ok) begin
               byte_a = {h_held.val, h_in.val};
            end else begin
               do_b   = 1'b1;
               do_raw = 1'b1;
            end
         end
         default: begin
            do_raw = 1'b1;
         end
      endcase

      group = '0;
      n     = '0;
      p     = prev;

      if (do_a) begin
         d = decode_byte(byte_a, p);
         p = d.prev;
         if (d.emit) begin
            group.data[n] = d.data;
            n = 2'(n + 2'd1);
         end
      end
      if (do_b) begin
         d = decode_byte(byte_b, p);
         p = d.prev;
         if (d.emit) begin
            group.data[n] = d.data;
            n = 2'(n + 2'd1);
         end
      end
      if (do_raw) begin
         if (is_term) begin
            group.data[n] = CH_NUL;
            group.eos[n]  = 1'b1;
            n = 2'(n + 2'd1);
            held_next = '0;
            p = '0;
         end else if (in_byte != CH_PERCENT) begin
            d = decode_byte(in_byte, p);
            p = d.prev;
            if (d.emit) begin
               group.data[n] = d.data;
               n = 2'(n + 2'd1);
            end
         end
      end
      group.cnt = n;
      prev_next = p;
   end

endmodule

// ===== rtl/u8k_rsp_queue.sv =====
// ============================================================================
// u8k_rsp_queue
// Result register holding one group of up to three beats, drained one beat
// per cycle onto the result channel while rsp_stall is low.
// ============================================================================
module u8k_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  u8k_pkg::group_type load_group,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_end_of_string
);
   import u8k_pkg::*;

   logic [1:0]      cnt_ff,  cnt_in;
   logic [2:0][7:0] data_ff, data_in;
   logic [2:0]      eos_ff,  eos_in;
   logic            take;

   assign rsp_valid         = (cnt_ff != 2'd0);
   assign rsp_out_byte      = data_ff[0];
   assign rsp_end_of_string = eos_ff[0];
   assign take              = rsp_valid && !rsp_stall;
   assign free              = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && take);

   always_comb begin
      cnt_in  = cnt_ff;
      data_in = data_ff;
      eos_in  = eos_ff;
      if (load) begin
         cnt_in  = load_group.cnt;
         data_in = load_group.data;
         eos_in  = load_group.eos;
      end else if (take) begin
         cnt_in  = 2'(cnt_ff - 2'd1);
         data_in = {8'h00, data_ff[2], data_ff[1]};
         eos_in  = {1'b0, eos_ff[2], eos_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      data_ff <= data_in;
      eos_ff  <= eos_in;
   end

endmodule

// ===== rtl/url_utf8_to_koi8r_decoder_unit.sv =====
// ============================================================================
// url_utf8_to_koi8r_decoder_unit
// URL percent decoder feeding a two-byte UTF-8 to KOI8-R converter.
// ============================================================================
//
//   channel | dir | ports                                  | per beat
//   --------+-----+----------------------------------------+------------------
//   req     | in  | req_valid, req_stall, req_in_byte      | one raw URL byte
//   rsp     | out | rsp_valid, rsp_stall, rsp_out_byte,    | one KOI8-R byte,
//           |     | rsp_end_of_string                      | last-of-string
//
// Flow: an accepted request beat is registered in the input register, then
//   decodes in one pass into the result register, which drives the rsp port.
//   Sustained rate is one request beat per cycle while each yields at most one
//   result and rsp_stall is low; a beat yielding more results holds the input
//   register until the last beat of the result register is being taken.
// Reset: synchronous, clears escape phase, held digit, lead byte and both
//   valid flags.
// Stalls: req_stall rises only when the input register is full and the result
//   register cannot take its group; rsp payload holds while rsp_stall is high.
//
module url_utf8_to_koi8r_decoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_end_of_string
);
   import u8k_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;

   // decoder state
   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff,  held_in;
   logic [7:0] prev_ff,  prev_in;

   phase_type  phase_nx;
   logic [7:0] held_nx;
   logic [7:0] prev_nx;
   group_type  group;
   logic       q_free;
   logic       fire;
   logic       req_take;

   // decode fires when the result register has room for a whole group
   assign fire      = in_valid_ff && q_free;
   assign req_stall = in_valid_ff && !q_free;
   assign req_take  = req_valid && !req_stall;

   u8k_step u_step (
      .in_byte    (in_byte_ff),
      .phase      (phase_ff),
      .held       (held_ff),
      .prev       (prev_ff),
      .phase_next (phase_nx),
      .held_next  (held_nx),
      .prev_next  (prev_nx),
      .group      (group)
   );

   u8k_rsp_queue u_queue (
      .clock             (clock),
      .reset             (reset),
      .load              (fire),
      .load_group        (group),
      .free              (q_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_end_of_string (rsp_end_of_string)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // state advances only on a decoded beat
   always_comb begin
      phase_in = phase_ff;
      held_in  = held_ff;
      prev_in  = prev_ff;
      if (fire) begin
         phase_in = phase_nx;
         held_in  = held_nx;
         prev_in  = prev_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         held_ff     <= '0;
         prev_ff     <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         prev_ff     <= prev_in;
      end
      in_byte_ff <= in_byte_in;
   end

endmodule

// ===== rtl/u8k_checker.sv =====
// ============================================================================
// u8k_checker
// Port-level assertions for the URL / UTF-8 to KOI8-R decoder.
// ============================================================================
module u8k_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_string
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
                                && $stable(rsp_end_of_string))
      else $error("rsp beat changed under stall");

   // last mark only on the zero terminator
   a_eos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> rsp_out_byte == 8'h00)
      else $error("end_of_string on nonzero byte");

   // empty result side never backs up the request side
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while no result pending");

   // reset leaves both channels quiet
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity right after reset");

   // stalled request beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_byte))
      else $error("req beat changed under stall");

endmodule

bind url_utf8_to_koi8r_decoder_unit u8k_checker u_chk (.*);
